// ----- hdl/nvpd_pkg.sv -----
// shared constants and types for the name-value pair deframer
`default_nettype none

package nvpd_pkg;

	typedef logic [2:0] phase_t;
	typedef logic [1:0] kind_t;

	localparam phase_t PH_NAME_HDR   = 3'd0;
	localparam phase_t PH_NAME_LONG  = 3'd1;
	localparam phase_t PH_VALUE_HDR  = 3'd2;
	localparam phase_t PH_VALUE_LONG = 3'd3;
	localparam phase_t PH_NAME       = 3'd4;
	localparam phase_t PH_VALUE      = 3'd5;
	localparam phase_t PH_DISCARD    = 3'd6;

	localparam kind_t KIND_HEADER  = 2'd0;
	localparam kind_t KIND_NAME    = 2'd1;
	localparam kind_t KIND_VALUE   = 2'd2;
	localparam kind_t KIND_DISCARD = 2'd3;

	localparam int LEN_W     = 31;
	localparam int CNT_W     = 4;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;
	localparam int LONG_REST = 3;

	localparam logic [ADDR_W-1:0] REG_MIN_PAIR_BYTES = 3'd0;
	localparam logic [CNT_W-1:0]  MIN_PAIR_RESET     = 4'd2;
	localparam logic [CNT_W-1:0]  CNT_MAX            = 4'd15;

	typedef logic [LEN_W-1:0] len_t;

endpackage

`default_nettype wire

// ----- hdl/name_value_pair_deframer.sv -----
// top level: name-value pair deframer for a params record body
// each result beat is registered and appears in the cycle after its input beat is accepted
// throughput: one byte per cycle while out_ready holds; the result register is refilled in the cycle it drains
// the length fields, counters and phase are updated in one pass per byte
// reset: arst_n clears the pair state and the output valid, min_pair_bytes returns to 2
`default_nettype none

module name_value_pair_deframer #(
	parameter int LENGTH_BITS = 31
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [nvpd_pkg::ADDR_W-1:0]     paddr,
	input  wire logic [nvpd_pkg::DATA_W-1:0]     pwdata,
	output logic      [nvpd_pkg::DATA_W-1:0]     prdata,
	output logic                                 pready,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [7:0]                      data_byte,
	input  wire logic                            last_byte,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [7:0]                           out_byte,
	output logic [1:0]                           byte_kind,
	output logic                                 header_done,
	output logic [nvpd_pkg::LEN_W-1:0]           name_len,
	output logic [nvpd_pkg::LEN_W-1:0]           value_len,
	output logic                                 pair_done,
	output logic                                 bad_pair
);

	localparam int LW = nvpd_pkg::LEN_W;
	localparam int CW = nvpd_pkg::CNT_W;
	localparam logic [LW-1:0] LEN_LIM = LW'((64'd1 << LENGTH_BITS) - 64'd1);

	// configuration
	logic [nvpd_pkg::CNT_W-1:0] min_pair_bytes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pair_bytes_q <= nvpd_pkg::MIN_PAIR_RESET;
		end else if (psel && penable && pwrite && pready &&
				paddr[nvpd_pkg::ADDR_W-1] == nvpd_pkg::REG_MIN_PAIR_BYTES[nvpd_pkg::ADDR_W-1]) begin
			min_pair_bytes_q <= pwdata[nvpd_pkg::CNT_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[nvpd_pkg::ADDR_W-1] ==
			nvpd_pkg::REG_MIN_PAIR_BYTES[nvpd_pkg::ADDR_W-1]) ?
			{{(nvpd_pkg::DATA_W-nvpd_pkg::CNT_W){1'b0}}, min_pair_bytes_q} :
			{nvpd_pkg::DATA_W{1'b0}};

	// pair state
	nvpd_pkg::phase_t           phase_q, phase_n;
	logic [nvpd_pkg::CNT_W-1:0] cnt_q, cnt_n;
	nvpd_pkg::len_t             nlen_q, nlen_n, vlen_q, vlen_n;
	logic [LENGTH_BITS-1:0]     left_q, left_n, left_dec;

	nvpd_pkg::kind_t kind;
	logic            hcomplete, hdone, pdone, bad, pending, too_wide, left_one;
	nvpd_pkg::len_t  onl, ovl;

	logic accept;
	assign in_ready = !out_valid || out_ready;
	assign accept   = in_valid && in_ready;

	assign left_dec = left_q - LENGTH_BITS'(1);
	assign left_one = (left_q == LENGTH_BITS'(1));

	always_comb begin
		phase_n   = phase_q;
		nlen_n    = nlen_q;
		vlen_n    = vlen_q;
		left_n    = left_q;
		kind      = nvpd_pkg::KIND_HEADER;
		hcomplete = 1'b0;
		hdone     = 1'b0;
		pdone     = 1'b0;
		bad       = 1'b0;
		onl       = '0;
		ovl       = '0;
		too_wide  = 1'b0;
		pending   = 1'b0;

		if (phase_q != nvpd_pkg::PH_DISCARD && cnt_q != nvpd_pkg::CNT_MAX) begin
			cnt_n = cnt_q + CW'(1);
		end else begin
			cnt_n = cnt_q;
		end

		unique case (phase_q)
			nvpd_pkg::PH_NAME_LONG: begin
				nlen_n = {nlen_q[LW-9:0], data_byte};
				left_n = left_dec;
				if (left_one) begin
					phase_n = nvpd_pkg::PH_VALUE_HDR;
				end
			end
			nvpd_pkg::PH_VALUE_HDR: begin
				if (!data_byte[7]) begin
					vlen_n    = LW'(data_byte);
					hcomplete = 1'b1;
				end else begin
					vlen_n  = LW'(data_byte[6:0]);
					left_n  = LENGTH_BITS'(nvpd_pkg::LONG_REST);
					phase_n = nvpd_pkg::PH_VALUE_LONG;
				end
			end
			nvpd_pkg::PH_VALUE_LONG: begin
				vlen_n = {vlen_q[LW-9:0], data_byte};
				left_n = left_dec;
				if (left_one) begin
					hcomplete = 1'b1;
				end
			end
			nvpd_pkg::PH_NAME: begin
				kind   = nvpd_pkg::KIND_NAME;
				left_n = left_dec;
				if (left_one) begin
					if (vlen_q != '0) begin
						phase_n = nvpd_pkg::PH_VALUE;
						left_n  = vlen_q[LENGTH_BITS-1:0];
					end else begin
						pdone = 1'b1;
					end
				end
			end
			nvpd_pkg::PH_VALUE: begin
				kind   = nvpd_pkg::KIND_VALUE;
				left_n = left_dec;
				if (left_one) begin
					pdone = 1'b1;
				end
			end
			nvpd_pkg::PH_DISCARD: begin
				kind = nvpd_pkg::KIND_DISCARD;
			end
			default: begin
				if (!data_byte[7]) begin
					nlen_n  = LW'(data_byte);
					phase_n = nvpd_pkg::PH_VALUE_HDR;
				end else begin
					nlen_n  = LW'(data_byte[6:0]);
					left_n  = LENGTH_BITS'(nvpd_pkg::LONG_REST);
					phase_n = nvpd_pkg::PH_NAME_LONG;
				end
			end
		endcase

		if (hcomplete) begin
			too_wide = ((nlen_n & ~LEN_LIM) != '0) || ((vlen_n & ~LEN_LIM) != '0);
			if (too_wide) begin
				bad     = 1'b1;
				phase_n = nvpd_pkg::PH_DISCARD;
				left_n  = '0;
			end else begin
				hdone = 1'b1;
				onl   = nlen_n;
				ovl   = vlen_n;
				if (nlen_n != '0) begin
					phase_n = nvpd_pkg::PH_NAME;
					left_n  = nlen_n[LENGTH_BITS-1:0];
				end else if (vlen_n != '0) begin
					phase_n = nvpd_pkg::PH_VALUE;
					left_n  = vlen_n[LENGTH_BITS-1:0];
				end else begin
					pdone = 1'b1;
				end
			end
		end

		if (pdone) begin
			phase_n = nvpd_pkg::PH_NAME_HDR;
			cnt_n   = '0;
			nlen_n  = '0;
			vlen_n  = '0;
			left_n  = '0;
		end

		if (last_byte) begin
			pending = (phase_n != nvpd_pkg::PH_NAME_HDR || cnt_n != '0) &&
					phase_n != nvpd_pkg::PH_DISCARD;
			if (pending && cnt_n >= min_pair_bytes_q) begin
				bad = 1'b1;
			end
			phase_n = nvpd_pkg::PH_NAME_HDR;
			cnt_n   = '0;
			nlen_n  = '0;
			vlen_n  = '0;
			left_n  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= nvpd_pkg::PH_NAME_HDR;
			cnt_q   <= '0;
			nlen_q  <= '0;
			vlen_q  <= '0;
			left_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			nlen_q  <= nlen_n;
			vlen_q  <= vlen_n;
			left_q  <= left_n;
		end
	end

	// result register
	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	nvpd_pkg::kind_t       kind_q;
	logic                  hdone_q, pdone_q, bad_q;
	nvpd_pkg::len_t        onl_q, ovl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_byte_q <= data_byte;
			kind_q     <= kind;
			hdone_q    <= hdone;
			onl_q      <= onl;
			ovl_q      <= ovl;
			pdone_q    <= pdone;
			bad_q      <= bad;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign byte_kind   = kind_q;
	assign header_done = hdone_q;
	assign name_len    = onl_q;
	assign value_len   = ovl_q;
	assign pair_done   = pdone_q;
	assign bad_pair    = bad_q;

endmodule

`default_nettype wire
